>>> hdl/fcbu_pkg.sv
// Shared constants, command codes and types of the fly camera basis update block.
package fcbu_pkg;

    // Event kinds
    localparam logic [1:0] OP_MOVE = 2'd0;
    localparam logic [1:0] OP_LOOK = 2'd1;
    localparam logic [1:0] OP_ZOOM = 2'd2;
    localparam logic [1:0] OP_NONE = 2'd3;

    // Move directions
    localparam logic [2:0] DIR_FWD   = 3'd0;
    localparam logic [2:0] DIR_BACK  = 3'd1;
    localparam logic [2:0] DIR_RIGHT = 3'd2;
    localparam logic [2:0] DIR_LEFT  = 3'd3;
    localparam logic [2:0] DIR_UP    = 3'd4;
    localparam logic [2:0] DIR_DOWN  = 3'd5;

    // Angles in degrees: pitch signed Q8.8, yaw Q9.8
    localparam logic signed [16:0] PITCH_LIM = 17'sd22784;
    localparam logic [16:0] YAW_FULL = 17'd92160;
    localparam logic [16:0] QUARTER  = 17'd23040;
    localparam logic [16:0] HALF     = 17'd46080;
    localparam logic [16:0] THREE_Q  = 17'd69120;

    // Field of view limits, Q6.8 degrees
    localparam logic signed [17:0] FOV_MIN = 18'sd256;
    localparam logic signed [17:0] FOV_MAX = 18'sd11520;
    localparam logic [13:0] FOV_RST = 14'd11520;

    // Move speed reset, Q8.8
    localparam logic [15:0] SPEED_RST = 16'd640;

    // Degrees Q8.8 to radians Q2.30, and one in Q30
    localparam logic [31:0] RAD_K   = 32'd73204;
    localparam logic [30:0] Q30_ONE = 31'd1073741824;
    localparam logic signed [15:0] ONE_Q14 = 16'sd16384;

    // Register byte offset of move_speed
    localparam logic ADDR_SPEED = 1'b0;

    // Datapath operations
    localparam logic [3:0] DP_NOP  = 4'd0;
    localparam logic [3:0] DP_LOAD = 4'd1;
    localparam logic [3:0] DP_LOOK = 4'd2;
    localparam logic [3:0] DP_ZOOM = 4'd3;
    localparam logic [3:0] DP_FOLD = 4'd4;
    localparam logic [3:0] DP_Z    = 4'd5;
    localparam logic [3:0] DP_Z2   = 4'd6;
    localparam logic [3:0] DP_DQ   = 4'd7;
    localparam logic [3:0] DP_DT   = 4'd8;
    localparam logic [3:0] DP_DM   = 4'd9;
    localparam logic [3:0] DP_S    = 4'd10;
    localparam logic [3:0] DP_PROD = 4'd11;
    localparam logic [3:0] DP_M1   = 4'd12;
    localparam logic [3:0] DP_M2   = 4'd13;
    localparam logic [3:0] DP_ADD  = 4'd14;
    localparam logic [3:0] DP_OUT  = 4'd15;

    typedef logic [3:0] dp_op_t;

    typedef struct packed {
        dp_op_t     op;
        logic [1:0] idx;
    } dp_cmd_t;

    // Series divisors, one per Horner round
    function automatic logic [6:0] div_const(input logic [1:0] rnd);
        logic [6:0] d;
        case (rnd)
            2'd0:    d = 7'd72;
            2'd1:    d = 7'd42;
            2'd2:    d = 7'd20;
            default: d = 7'd6;
        endcase
        return d;
    endfunction

    // floor(2^32 / divisor) for each round
    function automatic logic [31:0] div_recip(input logic [1:0] rnd);
        logic [31:0] m;
        case (rnd)
            2'd0:    m = 32'd59652323;
            2'd1:    m = 32'd102261126;
            2'd2:    m = 32'd214748364;
            default: m = 32'd715827882;
        endcase
        return m;
    endfunction

endpackage

>>> hdl/fcbu_dp.sv
// Datapath: camera state, trig series unit on one shared multiplier, move and output registers.
module fcbu_dp (
    input  logic                  clk,
    input  logic                  rst_n,
    input  fcbu_pkg::dp_cmd_t     cmd,
    input  logic                  cfg_wr,
    input  logic [15:0]           cfg_wdata,
    output logic [15:0]           speed_q,
    input  logic [2:0]            move_dir,
    input  logic [15:0]           time_step,
    input  logic signed [15:0]    pitch_delta,
    input  logic signed [15:0]    yaw_delta,
    input  logic signed [15:0]    zoom_delta,
    output logic signed [31:0]    pos_x,
    output logic signed [31:0]    pos_y,
    output logic signed [31:0]    pos_z,
    output logic signed [15:0]    fwd_x,
    output logic signed [15:0]    fwd_y,
    output logic signed [15:0]    fwd_z,
    output logic signed [15:0]    side_x,
    output logic signed [15:0]    side_z,
    output logic signed [15:0]    upv_x,
    output logic signed [15:0]    upv_y,
    output logic signed [15:0]    upv_z,
    output logic [13:0]           view_angle
);

    function automatic logic [14:0] abs15(input logic signed [15:0] v);
        logic signed [15:0] n;
        n = -v;
        return v[15] ? n[14:0] : v[14:0];
    endfunction

    // Camera state
    logic [15:0]        speed_reg;
    logic signed [31:0] px_reg, py_reg, pz_reg;
    logic signed [15:0] pitch_reg;
    logic [16:0]        yaw_reg;
    logic [13:0]        fov_reg;

    // Cached sines, cosines and their products
    logic signed [15:0] sp_reg, cp_reg, sy_reg, cy_reg;
    logic signed [15:0] mcc_reg, msc_reg, mpc_reg, mps_reg;

    // Latched request
    logic [2:0]         dir_reg;
    logic [15:0]        ts_reg;
    logic signed [15:0] pd_reg, yd_reg, zd_reg;

    // Series work registers
    logic [14:0] x_reg;
    logic        neg_reg;
    logic [30:0] z_reg;
    logic [31:0] z2_reg;
    logic [31:0] dv_reg;
    logic [31:0] q_reg;
    logic [30:0] t_reg;

    // Move work registers
    logic        mneg_reg;
    logic [30:0] m1_reg;
    logic [25:0] d_reg;

    // Output registers
    logic signed [31:0] opx_reg, opy_reg, opz_reg;
    logic signed [15:0] ofx_reg, ofy_reg, ofz_reg, osx_reg, osz_reg;
    logic signed [15:0] oux_reg, ouy_reg, ouz_reg;
    logic [13:0]        ofov_reg;

    // Shared multiplier
    logic [31:0] mul_a, mul_b;
    logic [63:0] prod;

    // Product operand pick
    logic signed [15:0] pa, pb;
    logic [14:0] pa_mag, pb_mag;
    logic        p_neg;
    logic [15:0] p_rnd;
    logic signed [15:0] p_res;

    // Move component pick
    logic signed [15:0] comp;
    logic [14:0] cmag;

    always_comb
    begin
        case (cmd.idx)
            2'd0:    begin pa = cy_reg; pb = cp_reg; end
            2'd1:    begin pa = sy_reg; pb = cp_reg; end
            2'd2:    begin pa = sp_reg; pb = cy_reg; end
            default: begin pa = sp_reg; pb = sy_reg; end
        endcase
        pa_mag = abs15(pa);
        pb_mag = abs15(pb);
        p_neg  = pa[15] ^ pb[15];
    end

    // Pick the signed component of the move along the current axis
    always_comb
    begin
        comp = '0;
        case (cmd.idx)
            2'd0:
                case (dir_reg)
                    fcbu_pkg::DIR_FWD:   comp = mcc_reg;
                    fcbu_pkg::DIR_BACK:  comp = -mcc_reg;
                    fcbu_pkg::DIR_RIGHT: comp = sy_reg;
                    fcbu_pkg::DIR_LEFT:  comp = -sy_reg;
                    default:             comp = '0;
                endcase
            2'd1:
                case (dir_reg)
                    fcbu_pkg::DIR_FWD:  comp = sp_reg;
                    fcbu_pkg::DIR_BACK: comp = -sp_reg;
                    fcbu_pkg::DIR_UP:   comp = fcbu_pkg::ONE_Q14;
                    fcbu_pkg::DIR_DOWN: comp = -fcbu_pkg::ONE_Q14;
                    default:            comp = '0;
                endcase
            default:
                case (dir_reg)
                    fcbu_pkg::DIR_FWD:   comp = -msc_reg;
                    fcbu_pkg::DIR_BACK:  comp = msc_reg;
                    fcbu_pkg::DIR_RIGHT: comp = cy_reg;
                    fcbu_pkg::DIR_LEFT:  comp = -cy_reg;
                    default:             comp = '0;
                endcase
        endcase
        cmag = abs15(comp);
    end

    // Select multiplier operands
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            fcbu_pkg::DP_Z:    begin mul_a = {17'd0, x_reg}; mul_b = fcbu_pkg::RAD_K; end
            fcbu_pkg::DP_Z2:   begin mul_a = {1'b0, z_reg}; mul_b = {1'b0, z_reg}; end
            fcbu_pkg::DP_DQ:   begin mul_a = dv_reg; mul_b = fcbu_pkg::div_recip(cmd.idx); end
            fcbu_pkg::DP_DM:   begin mul_a = z2_reg; mul_b = {1'b0, t_reg}; end
            fcbu_pkg::DP_S:    begin mul_a = {1'b0, z_reg}; mul_b = {1'b0, t_reg}; end
            fcbu_pkg::DP_PROD: begin mul_a = {17'd0, pa_mag}; mul_b = {17'd0, pb_mag}; end
            fcbu_pkg::DP_M1:   begin mul_a = {17'd0, cmag}; mul_b = {16'd0, speed_reg}; end
            fcbu_pkg::DP_M2:   begin mul_a = {1'b0, m1_reg}; mul_b = {16'd0, ts_reg}; end
            default:           begin mul_a = '0; mul_b = '0; end
        endcase
    end

    assign prod = mul_a * mul_b;

    // Round a Q1.14 product half away from zero
    always_comb
    begin
        p_rnd = 16'((prod[29:0] + 30'd8192) >> 14);
        p_res = p_neg ? -$signed(p_rnd) : $signed(p_rnd);
    end

    // Fold an angle into the first quadrant
    logic signed [17:0] f_ang;
    logic [16:0] f_mod, f_rem;
    logic [1:0]  f_quad;
    logic [14:0] f_x;

    always_comb
    begin
        case (cmd.idx)
            2'd0:    f_ang = 18'(pitch_reg);
            2'd1:    f_ang = 18'(pitch_reg) + 18'sd23040;
            2'd2:    f_ang = $signed({1'b0, yaw_reg});
            default: f_ang = $signed({1'b0, yaw_reg}) + 18'sd23040;
        endcase
        if (f_ang < 0)
            f_mod = 17'(f_ang + 18'sd92160);
        else if (f_ang >= 18'sd92160)
            f_mod = 17'(f_ang - 18'sd92160);
        else
            f_mod = f_ang[16:0];
        if (f_mod < fcbu_pkg::QUARTER)
        begin
            f_quad = 2'd0; f_rem = f_mod;
        end
        else if (f_mod < fcbu_pkg::HALF)
        begin
            f_quad = 2'd1; f_rem = f_mod - fcbu_pkg::QUARTER;
        end
        else if (f_mod < fcbu_pkg::THREE_Q)
        begin
            f_quad = 2'd2; f_rem = f_mod - fcbu_pkg::HALF;
        end
        else
        begin
            f_quad = 2'd3; f_rem = f_mod - fcbu_pkg::THREE_Q;
        end
        f_x = f_quad[0] ? 15'(fcbu_pkg::QUARTER - f_rem) : f_rem[14:0];
    end

    // Division correction and next series term
    logic [6:0]  dc;
    logic [31:0] rem;
    logic [31:0] qfix;
    always_comb
    begin
        dc   = fcbu_pkg::div_const(cmd.idx);
        rem  = dv_reg - 32'(q_reg * {25'd0, dc});
        qfix = q_reg + ((rem >= {25'd0, dc}) ? 32'd1 : 32'd0);
    end

    // Final sine rounding
    logic [32:0] s_sum;
    logic [16:0] s_raw;
    logic signed [15:0] s_val;
    always_comb
    begin
        s_sum = prod[62:30] + 33'd32768;
        s_raw = s_sum[32:16];
        if (s_raw > 17'd16384)
            s_val = fcbu_pkg::ONE_Q14;
        else
            s_val = $signed({1'b0, s_raw[14:0]});
        if (neg_reg)
            s_val = -s_val;
    end

    // Look and zoom arithmetic
    logic signed [16:0] lk_p;
    logic signed [17:0] lk_y;
    logic signed [15:0] pitch_next;
    logic [16:0]        yaw_next;
    logic signed [17:0] zm_f;
    logic [13:0]        fov_next;
    always_comb
    begin
        lk_p = 17'(pitch_reg) + 17'(pd_reg);
        if (lk_p > fcbu_pkg::PITCH_LIM)
            pitch_next = 16'(fcbu_pkg::PITCH_LIM);
        else if (lk_p < -fcbu_pkg::PITCH_LIM)
            pitch_next = 16'(-fcbu_pkg::PITCH_LIM);
        else
            pitch_next = lk_p[15:0];
        lk_y = $signed({1'b0, yaw_reg}) + 18'(yd_reg);
        if (lk_y > 18'sd92160)
            yaw_next = '0;
        else if (lk_y < 0)
            yaw_next = fcbu_pkg::YAW_FULL;
        else
            yaw_next = lk_y[16:0];
        zm_f = $signed({4'd0, fov_reg}) - 18'(zd_reg);
        if (zm_f < fcbu_pkg::FOV_MIN)
            fov_next = 14'(fcbu_pkg::FOV_MIN);
        else if (zm_f > fcbu_pkg::FOV_MAX)
            fov_next = 14'(fcbu_pkg::FOV_MAX);
        else
            fov_next = zm_f[13:0];
    end

    // Saturating position add
    logic [47:0]        m2_sum;
    logic signed [31:0] pos_cur;
    logic signed [33:0] add_sum;
    logic signed [31:0] pos_next;
    always_comb
    begin
        m2_sum = prod[47:0] + 48'd2097152;
        case (cmd.idx)
            2'd0:    pos_cur = px_reg;
            2'd1:    pos_cur = py_reg;
            default: pos_cur = pz_reg;
        endcase
        if (mneg_reg)
            add_sum = 34'(pos_cur) - $signed({8'd0, d_reg});
        else
            add_sum = 34'(pos_cur) + $signed({8'd0, d_reg});
        if (add_sum > 34'sd2147483647)
            pos_next = 32'sh7FFFFFFF;
        else if (add_sum < -34'sd2147483648)
            pos_next = 32'sh80000000;
        else
            pos_next = add_sum[31:0];
    end

    // Hold camera state, cached vectors and move speed
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_reg <= fcbu_pkg::SPEED_RST;
            px_reg    <= '0;
            py_reg    <= '0;
            pz_reg    <= '0;
            pitch_reg <= '0;
            yaw_reg   <= '0;
            fov_reg   <= fcbu_pkg::FOV_RST;
            sp_reg    <= '0;
            cp_reg    <= fcbu_pkg::ONE_Q14;
            sy_reg    <= '0;
            cy_reg    <= fcbu_pkg::ONE_Q14;
            mcc_reg   <= fcbu_pkg::ONE_Q14;
            msc_reg   <= '0;
            mpc_reg   <= '0;
            mps_reg   <= '0;
        end
        else
        begin
            if (cfg_wr)
                speed_reg <= cfg_wdata;
            case (cmd.op)
                fcbu_pkg::DP_LOOK:
                begin
                    pitch_reg <= pitch_next;
                    yaw_reg   <= yaw_next;
                end
                fcbu_pkg::DP_ZOOM:
                    fov_reg <= fov_next;
                fcbu_pkg::DP_S:
                    case (cmd.idx)
                        2'd0:    sp_reg <= s_val;
                        2'd1:    cp_reg <= s_val;
                        2'd2:    sy_reg <= s_val;
                        default: cy_reg <= s_val;
                    endcase
                fcbu_pkg::DP_PROD:
                    case (cmd.idx)
                        2'd0:    mcc_reg <= p_res;
                        2'd1:    msc_reg <= p_res;
                        2'd2:    mpc_reg <= p_res;
                        default: mps_reg <= p_res;
                    endcase
                fcbu_pkg::DP_ADD:
                    case (cmd.idx)
                        2'd0:    px_reg <= pos_next;
                        2'd1:    py_reg <= pos_next;
                        default: pz_reg <= pos_next;
                    endcase
                default:
                begin
                end
            endcase
        end
    end

    // Advance work registers
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            fcbu_pkg::DP_LOAD:
            begin
                dir_reg <= move_dir;
                ts_reg  <= time_step;
                pd_reg  <= pitch_delta;
                yd_reg  <= yaw_delta;
                zd_reg  <= zoom_delta;
            end
            fcbu_pkg::DP_FOLD:
            begin
                x_reg   <= f_x;
                neg_reg <= f_quad[1];
            end
            fcbu_pkg::DP_Z:
                z_reg <= prod[30:0];
            fcbu_pkg::DP_Z2:
            begin
                z2_reg <= prod[61:30];
                dv_reg <= prod[61:30];
            end
            fcbu_pkg::DP_DQ:
                q_reg <= prod[63:32];
            fcbu_pkg::DP_DT:
                t_reg <= fcbu_pkg::Q30_ONE - qfix[30:0];
            fcbu_pkg::DP_DM:
                dv_reg <= prod[61:30];
            fcbu_pkg::DP_M1:
            begin
                m1_reg   <= prod[30:0];
                mneg_reg <= comp[15];
            end
            fcbu_pkg::DP_M2:
                d_reg <= m2_sum[47:22];
            fcbu_pkg::DP_OUT:
            begin
                opx_reg  <= px_reg;
                opy_reg  <= py_reg;
                opz_reg  <= pz_reg;
                ofx_reg  <= mcc_reg;
                ofy_reg  <= sp_reg;
                ofz_reg  <= -msc_reg;
                osx_reg  <= -sy_reg;
                osz_reg  <= -cy_reg;
                oux_reg  <= -mpc_reg;
                ouy_reg  <= cp_reg;
                ouz_reg  <= mps_reg;
                ofov_reg <= fov_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign speed_q    = speed_reg;
    assign pos_x      = opx_reg;
    assign pos_y      = opy_reg;
    assign pos_z      = opz_reg;
    assign fwd_x      = ofx_reg;
    assign fwd_y      = ofy_reg;
    assign fwd_z      = ofz_reg;
    assign side_x     = osx_reg;
    assign side_z     = osz_reg;
    assign upv_x      = oux_reg;
    assign upv_y      = ouy_reg;
    assign upv_z      = ouz_reg;
    assign view_angle = ofov_reg;

endmodule

>>> hdl/fcbu_ctrl.sv
// Controller: sequences each request through the datapath and owns the handshakes.
module fcbu_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         op,
    output logic               out_valid,
    input  logic               out_ready,
    output fcbu_pkg::dp_cmd_t  cmd
);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_LOOK = 4'd1;
    localparam logic [3:0] ST_FOLD = 4'd2;
    localparam logic [3:0] ST_Z    = 4'd3;
    localparam logic [3:0] ST_Z2   = 4'd4;
    localparam logic [3:0] ST_DQ   = 4'd5;
    localparam logic [3:0] ST_DT   = 4'd6;
    localparam logic [3:0] ST_DM   = 4'd7;
    localparam logic [3:0] ST_S    = 4'd8;
    localparam logic [3:0] ST_PROD = 4'd9;
    localparam logic [3:0] ST_M1   = 4'd10;
    localparam logic [3:0] ST_M2   = 4'd11;
    localparam logic [3:0] ST_ADD  = 4'd12;
    localparam logic [3:0] ST_ZOOM = 4'd13;
    localparam logic [3:0] ST_OUT  = 4'd14;

    logic [3:0] state_reg, state_next;
    logic [1:0] idx_reg, idx_next;
    logic [1:0] rnd_reg, rnd_next;
    logic       out_valid_reg, out_valid_next;

    // Next state and datapath command
    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        rnd_next       = rnd_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd.op         = fcbu_pkg::DP_NOP;
        cmd.idx        = idx_reg;
        unique case (state_reg)
            ST_IDLE:
                if (in_valid)
                begin
                    cmd.op   = fcbu_pkg::DP_LOAD;
                    idx_next = '0;
                    unique case (op)
                        fcbu_pkg::OP_MOVE: state_next = ST_M1;
                        fcbu_pkg::OP_LOOK: state_next = ST_LOOK;
                        fcbu_pkg::OP_ZOOM: state_next = ST_ZOOM;
                        default:           state_next = ST_OUT;
                    endcase
                end
            ST_LOOK:
            begin
                cmd.op     = fcbu_pkg::DP_LOOK;
                state_next = ST_FOLD;
            end
            ST_FOLD:
            begin
                cmd.op     = fcbu_pkg::DP_FOLD;
                state_next = ST_Z;
            end
            ST_Z:
            begin
                cmd.op     = fcbu_pkg::DP_Z;
                state_next = ST_Z2;
            end
            ST_Z2:
            begin
                cmd.op     = fcbu_pkg::DP_Z2;
                rnd_next   = '0;
                state_next = ST_DQ;
            end
            ST_DQ:
            begin
                cmd.op     = fcbu_pkg::DP_DQ;
                cmd.idx    = rnd_reg;
                state_next = ST_DT;
            end
            ST_DT:
            begin
                cmd.op     = fcbu_pkg::DP_DT;
                cmd.idx    = rnd_reg;
                state_next = (rnd_reg == 2'd3) ? ST_S : ST_DM;
            end
            ST_DM:
            begin
                cmd.op     = fcbu_pkg::DP_DM;
                rnd_next   = rnd_reg + 2'd1;
                state_next = ST_DQ;
            end
            ST_S:
            begin
                cmd.op   = fcbu_pkg::DP_S;
                idx_next = idx_reg + 2'd1;
                state_next = (idx_reg == 2'd3) ? ST_PROD : ST_FOLD;
            end
            ST_PROD:
            begin
                cmd.op   = fcbu_pkg::DP_PROD;
                idx_next = idx_reg + 2'd1;
                if (idx_reg == 2'd3)
                    state_next = ST_OUT;
            end
            ST_M1:
            begin
                cmd.op     = fcbu_pkg::DP_M1;
                state_next = ST_M2;
            end
            ST_M2:
            begin
                cmd.op     = fcbu_pkg::DP_M2;
                state_next = ST_ADD;
            end
            ST_ADD:
            begin
                cmd.op   = fcbu_pkg::DP_ADD;
                idx_next = idx_reg + 2'd1;
                state_next = (idx_reg == 2'd2) ? ST_OUT : ST_M1;
            end
            ST_ZOOM:
            begin
                cmd.op     = fcbu_pkg::DP_ZOOM;
                state_next = ST_OUT;
            end
            ST_OUT:
                if (!out_valid_reg || out_ready)
                begin
                    cmd.op         = fcbu_pkg::DP_OUT;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            rnd_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            rnd_reg       <= rnd_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

>>> hdl/fly_camera_basis_update_top.sv
// Top level of the fly camera basis update block: register port, controller and datapath.
//
//  channel  | handshake            | payload
//  ---------+----------------------+-----------------------------------------------
//  request  | in_valid / in_ready  | op, move_dir, time_step, pitch/yaw/zoom_delta
//  result   | out_valid / out_ready| pos_*, fwd_*, side_*, upv_*, view_angle
//  config   | psel/penable/pwrite  | paddr, pwdata, prdata (move_speed at 0)
//
// One request at a time. A move runs three axes of two multiplies and a
// saturating add each; a look runs four sine series of 15 steps each and
// four vector products, all on one shared 32x32 multiplier.
// A finished result sits in the output register; the next request is taken
// while it waits, and only its own result stalls until the slot frees.
// Reset restores position, angles, field of view, cached vectors and speed.
module fly_camera_basis_update_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         op,
    input  logic [2:0]         move_dir,
    input  logic [15:0]        time_step,
    input  logic signed [15:0] pitch_delta,
    input  logic signed [15:0] yaw_delta,
    input  logic signed [15:0] zoom_delta,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] pos_x,
    output logic signed [31:0] pos_y,
    output logic signed [31:0] pos_z,
    output logic signed [15:0] fwd_x,
    output logic signed [15:0] fwd_y,
    output logic signed [15:0] fwd_z,
    output logic signed [15:0] side_x,
    output logic signed [15:0] side_z,
    output logic signed [15:0] upv_x,
    output logic signed [15:0] upv_y,
    output logic signed [15:0] upv_z,
    output logic [13:0]        view_angle,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    fcbu_pkg::dp_cmd_t cmd;
    logic              cfg_wr;
    logic [15:0]       speed_q;

    // Decode register writes and reads
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == fcbu_pkg::ADDR_SPEED);
    assign prdata = (paddr[2] == fcbu_pkg::ADDR_SPEED) ? {16'd0, speed_q} : 32'd0;

    fcbu_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .op        (op),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    fcbu_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .cfg_wr      (cfg_wr),
        .cfg_wdata   (pwdata[15:0]),
        .speed_q     (speed_q),
        .move_dir    (move_dir),
        .time_step   (time_step),
        .pitch_delta (pitch_delta),
        .yaw_delta   (yaw_delta),
        .zoom_delta  (zoom_delta),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .pos_z       (pos_z),
        .fwd_x       (fwd_x),
        .fwd_y       (fwd_y),
        .fwd_z       (fwd_z),
        .side_x      (side_x),
        .side_z      (side_z),
        .upv_x       (upv_x),
        .upv_y       (upv_y),
        .upv_z       (upv_z),
        .view_angle  (view_angle)
    );

endmodule

>>> test/fcbu_checker.sv
// Result checker for the fly camera basis update block: predicts camera state per request.
module fcbu_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic [1:0]         op,
    input  logic [2:0]         move_dir,
    input  logic [15:0]        time_step,
    input  logic signed [15:0] pitch_delta,
    input  logic signed [15:0] yaw_delta,
    input  logic signed [15:0] zoom_delta,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] pos_z,
    input  logic signed [15:0] fwd_x,
    input  logic signed [15:0] fwd_y,
    input  logic signed [15:0] fwd_z,
    input  logic signed [15:0] side_x,
    input  logic signed [15:0] side_z,
    input  logic signed [15:0] upv_x,
    input  logic signed [15:0] upv_y,
    input  logic signed [15:0] upv_z,
    input  logic [13:0]        view_angle,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    input  logic               pready,
    output int                 pending,
    output int                 err_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [31:0] px, py, pz;
        logic signed [15:0] fx, fy, fz, sx, sz, ux, uy, uz;
        logic [13:0]        fov;
    } view_t;

    view_t       view_q[$];
    int          cam_pos[3];
    int          cam_pitch, cam_yaw, cam_fov;
    int unsigned cam_speed;

    // Horner series of sine on the first quadrant, Q30 inside
    function automatic int quad_sine(int x);
        longint unsigned z, z2, t, s;
        z  = longint'(x) * 73204;
        z2 = (z * z) >> 30;
        t  = 64'd1073741824 - z2 / 72;
        t  = 64'd1073741824 - ((z2 * t) >> 30) / 42;
        t  = 64'd1073741824 - ((z2 * t) >> 30) / 20;
        t  = 64'd1073741824 - ((z2 * t) >> 30) / 6;
        s  = (((z * t) >> 30) + 32768) >> 16;
        if (s > 16384) s = 16384;
        return int'(s);
    endfunction

    function automatic int sine_q14(int a);
        int m, q, r;
        m = a % 92160;
        if (m < 0) m += 92160;
        q = m / 23040;
        r = m % 23040;
        case (q)
            0: return quad_sine(r);
            1: return quad_sine(23040 - r);
            2: return -quad_sine(r);
            default: return -quad_sine(23040 - r);
        endcase
    endfunction

    function automatic int prod_q14(int a, int b);
        int p;
        p = a * b;
        if (p < 0) return -(((-p) + 8192) >>> 14);
        return (p + 8192) >>> 14;
    endfunction

    // Advance one axis by comp * speed * dt, saturating
    task automatic step_axis(int k, int comp, int unsigned dt);
        longint unsigned mag, m;
        longint sum;
        mag = 64'((comp < 0) ? -comp : comp);
        m   = (mag * cam_speed * dt + (64'd1 << 21)) >> 22;
        sum = longint'(cam_pos[k]) + ((comp < 0) ? -longint'(m) : longint'(m));
        if (sum > 64'sd2147483647) sum = 64'sd2147483647;
        if (sum < -64'sd2147483648) sum = -64'sd2147483648;
        cam_pos[k] = int'(sum);
    endtask

    task automatic predict_view(logic [1:0] kind, logic [2:0] dir, logic [15:0] dt,
                                int pd, int yd, int zd);
        int sp, cp, sy, cy, fxv, fzv, g, p, y, f;
        view_t v;
        sp = sine_q14(cam_pitch);
        cp = sine_q14(cam_pitch + 23040);
        sy = sine_q14(cam_yaw);
        cy = sine_q14(cam_yaw + 23040);
        if (kind == fcbu_pkg::OP_MOVE) begin
            fxv = prod_q14(cy, cp);
            fzv = -prod_q14(sy, cp);
            if (dir == fcbu_pkg::DIR_FWD || dir == fcbu_pkg::DIR_BACK) begin
                g = (dir == fcbu_pkg::DIR_FWD) ? 1 : -1;
                step_axis(0, g * fxv, 32'(dt));
                step_axis(1, g * sp, 32'(dt));
                step_axis(2, g * fzv, 32'(dt));
            end else if (dir == fcbu_pkg::DIR_RIGHT || dir == fcbu_pkg::DIR_LEFT) begin
                g = (dir == fcbu_pkg::DIR_LEFT) ? 1 : -1;
                step_axis(0, -g * sy, 32'(dt));
                step_axis(2, -g * cy, 32'(dt));
            end else if (dir == fcbu_pkg::DIR_UP) begin
                step_axis(1, 16384, 32'(dt));
            end else if (dir == fcbu_pkg::DIR_DOWN) begin
                step_axis(1, -16384, 32'(dt));
            end
        end else if (kind == fcbu_pkg::OP_LOOK) begin
            p = cam_pitch + pd;
            y = cam_yaw + yd;
            if (p > 22784) p = 22784;
            if (p < -22784) p = -22784;
            if (y > 92160) y = 0;
            if (y < 0) y = 92160;
            cam_pitch = p;
            cam_yaw = y;
            sp = sine_q14(cam_pitch);
            cp = sine_q14(cam_pitch + 23040);
            sy = sine_q14(cam_yaw);
            cy = sine_q14(cam_yaw + 23040);
        end else if (kind == fcbu_pkg::OP_ZOOM) begin
            f = cam_fov - zd;
            if (f < 256) f = 256;
            if (f > 11520) f = 11520;
            cam_fov = f;
        end
        v.px = cam_pos[0];
        v.py = cam_pos[1];
        v.pz = cam_pos[2];
        v.fx = 16'(prod_q14(cy, cp));
        v.fy = 16'(sp);
        v.fz = 16'(-prod_q14(sy, cp));
        v.sx = 16'(-sy);
        v.sz = 16'(-cy);
        v.ux = 16'(-prod_q14(sp, cy));
        v.uy = 16'(cp);
        v.uz = 16'(prod_q14(sp, sy));
        v.fov = 14'(cam_fov);
        view_q.push_back(v);
    endtask

    task automatic flag(string name, longint exp_v, longint got_v);
        if (err_count < 10)
            $display("mismatch %s: expected %0d, got %0d", name, exp_v, got_v);
        err_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        view_t e;
        if (!rst_n)
        begin
            view_q.delete();
            cam_pos = '{0, 0, 0};
            cam_pitch = 0;
            cam_yaw = 0;
            cam_fov = 11520;
            cam_speed = 640;
            err_count = 0;
            pending = 0;
        end
        else
        begin
            // track speed writes
            if (psel && penable && pwrite && pready && paddr[2] == 1'b0)
                cam_speed = 32'(pwdata[15:0]);
            // predict each accepted request
            if (in_valid && in_ready)
                predict_view(op, move_dir, time_step, 32'(pitch_delta), 32'(yaw_delta),
                             32'(zoom_delta));
            // compare each accepted result
            if (out_valid && out_ready)
            begin
                if (view_q.size() == 0)
                begin
                    if (err_count < 10) $display("result with no request waiting");
                    err_count++;
                end
                else
                begin
                    e = view_q.pop_front();
                    if (e.px != pos_x) flag("pos_x", e.px, pos_x);
                    if (e.py != pos_y) flag("pos_y", e.py, pos_y);
                    if (e.pz != pos_z) flag("pos_z", e.pz, pos_z);
                    if (e.fx != fwd_x) flag("fwd_x", e.fx, fwd_x);
                    if (e.fy != fwd_y) flag("fwd_y", e.fy, fwd_y);
                    if (e.fz != fwd_z) flag("fwd_z", e.fz, fwd_z);
                    if (e.sx != side_x) flag("side_x", e.sx, side_x);
                    if (e.sz != side_z) flag("side_z", e.sz, side_z);
                    if (e.ux != upv_x) flag("upv_x", e.ux, upv_x);
                    if (e.uy != upv_y) flag("upv_y", e.uy, upv_y);
                    if (e.uz != upv_z) flag("upv_z", e.uz, upv_z);
                    if (e.fov != view_angle) flag("view_angle", e.fov, view_angle);
                end
            end
            pending = view_q.size();
        end
    end
endmodule

>>> test/tb.sv
// Testbench top of the fly camera basis update block: stimulus, register writes and verdict.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [1:0]         op = fcbu_pkg::OP_MOVE;
    logic [2:0]         move_dir = fcbu_pkg::DIR_FWD;
    logic [15:0]        time_step = '0;
    logic signed [15:0] pitch_delta = '0;
    logic signed [15:0] yaw_delta = '0;
    logic signed [15:0] zoom_delta = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic signed [31:0] pos_x, pos_y, pos_z;
    logic signed [15:0] fwd_x, fwd_y, fwd_z, side_x, side_z, upv_x, upv_y, upv_z;
    logic [13:0]        view_angle;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [2:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;
    int                 pending, err_count;
    int                 idle_pct = 18;
    int                 quiet_cycles = 0;
    logic [15:0]        speeds [5];

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    fly_camera_basis_update_top i_dut (.*);

    fcbu_checker i_check (.*);

    // random result stalls
    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= idle_pct);
    end

    // watchdog on cycles without any accepted request or result
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 5000)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic write_speed(logic [15:0] val);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= 3'd0; pwdata <= {16'd0, val};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send(logic [1:0] k, logic [2:0] d, logic [15:0] dt,
                        logic [15:0] pd, logic [15:0] yd, logic [15:0] zd);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        op <= k; move_dir <= d; time_step <= dt;
        pitch_delta <= pd; yaw_delta <= yd; zoom_delta <= zd;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    task automatic send_random;
        int r;
        logic [1:0] k;
        r = $urandom_range(99);
        k = (r < 40) ? fcbu_pkg::OP_MOVE : (r < 75) ? fcbu_pkg::OP_LOOK :
            (r < 95) ? fcbu_pkg::OP_ZOOM : fcbu_pkg::OP_NONE;
        send(k, (r % 10 == 0) ? 3'($urandom) : 3'($urandom_range(5)), 16'($urandom),
             ($urandom_range(3) == 0) ? 16'($urandom) : 16'($signed($urandom_range(6000)) - 3000),
             ($urandom_range(3) == 0) ? 16'($urandom) : 16'($signed($urandom_range(24000)) - 12000),
             16'($urandom));
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, every op and direction, clamps and wraps
        send(fcbu_pkg::OP_MOVE, fcbu_pkg::DIR_FWD, 16'hFFFF, 16'd0, 16'd0, 16'd0);
        send(fcbu_pkg::OP_LOOK, 3'd0, 16'd0, 16'sh7FFF, 16'sh7FFF, 16'd0);
        send(fcbu_pkg::OP_LOOK, 3'd0, 16'd0, 16'sh8000, 16'sh8000, 16'd0);
        send(fcbu_pkg::OP_LOOK, 3'd0, 16'd0, 16'sd0, 16'sh8000, 16'd0);
        send(fcbu_pkg::OP_LOOK, 3'd0, 16'd0, 16'sd11520, 16'sd30000, 16'd0);
        for (int d = 0; d < 8; d++)
            send(fcbu_pkg::OP_MOVE, 3'(d), 16'hFFFF, 16'd0, 16'd0, 16'd0);
        send(fcbu_pkg::OP_MOVE, fcbu_pkg::DIR_BACK, 16'd0, 16'd0, 16'd0, 16'd0);
        send(fcbu_pkg::OP_ZOOM, 3'd0, 16'd0, 16'd0, 16'd0, 16'sh7FFF);
        send(fcbu_pkg::OP_ZOOM, 3'd0, 16'd0, 16'd0, 16'd0, 16'sh8000);
        send(fcbu_pkg::OP_ZOOM, 3'd0, 16'd0, 16'd0, 16'd0, 16'sd1000);
        send(fcbu_pkg::OP_NONE, 3'd7, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        drain();

        // random phases over several speeds, extremes first
        speeds = '{16'hFFFF, 16'd0, 16'd1, 16'd640, 16'($urandom)};
        foreach (speeds[s])
        begin
            write_speed(speeds[s]);
            idle_pct = (s == 2) ? 0 : 18;
            repeat (290) send_random();
            drain();
        end
        idle_pct = 18;

        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule

>>> filelist.f
hdl/fcbu_pkg.sv
hdl/fcbu_dp.sv
hdl/fcbu_ctrl.sv
hdl/fly_camera_basis_update_top.sv
test/fcbu_checker.sv
test/tb.sv
